/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by sorted_priority_queue
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked on every edge
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/spq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and defaults for the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 16;
    localparam int PRIO_BITS_DEF    = 16;
    localparam int CMD_BITS         = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

endpackage

/* design/spq_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, shifts right on insert at or
// ahead of it, shifts left on pop.
// ---------------------------------------------------------------------------
module spq_cell #(
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF
) (
    input  logic                    i_clk,
    input  spq_pkg::t_cell_ctrl     i_ctrl,
    input  logic                    i_occupied,
    input  logic [PRIO_BITS-1:0]    i_new_prio,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic                    i_left_ge,
    input  logic [PRIO_BITS-1:0]    i_left_prio,
    input  logic [PAYLOAD_BITS-1:0] i_left_payload,
    input  logic [PRIO_BITS-1:0]    i_right_prio,
    input  logic [PAYLOAD_BITS-1:0] i_right_payload,
    output logic                    o_ge,
    output logic [PRIO_BITS-1:0]    o_prio,
    output logic [PAYLOAD_BITS-1:0] o_payload,
    output logic [PRIO_BITS-1:0]    o_next_prio,
    output logic [PAYLOAD_BITS-1:0] o_next_payload
);

    logic [PRIO_BITS-1:0]    r_prio;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [PRIO_BITS-1:0]    n_prio;
    logic [PAYLOAD_BITS-1:0] n_payload;

    assign o_ge = !i_occupied || (r_prio >= i_new_prio);

    always_comb begin
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_ctrl.insert && o_ge) begin
            if (i_left_ge) begin
                n_prio    = i_left_prio;
                n_payload = i_left_payload;
            end else begin
                n_prio    = i_new_prio;
                n_payload = i_new_payload;
            end
        end else if (i_ctrl.pop) begin
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

    assign o_prio         = r_prio;
    assign o_payload      = r_payload;
    assign o_next_prio    = n_prio;
    assign o_next_payload = n_payload;

endmodule

/* design/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-priority queue held as a sorted row of entry cells.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+--------------------------------
//  command | in        | i_valid / o_stall  | i_cmd, i_payload, i_prio
//  result  | out       | o_valid / i_stall  | o_head_payload, o_head_prio,
//          |           |                    | o_is_empty, o_fill_count,
//          |           |                    | o_overflow
//
//  One item per cycle unless the result is stalled; its result is registered
//  and appears the next cycle. Every cell compares against the new priority
//  in parallel, so insert and pop time does not depend on fill level.
//  Reset empties the queue; slot contents are not cleared.
//  A pending result that is stalled holds the input stalled as well.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue #(
    parameter int CAPACITY     = spq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
    parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF,
    localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [spq_pkg::CMD_BITS-1:0] i_cmd,
    input  logic [PAYLOAD_BITS-1:0]      i_payload,
    input  logic [PRIO_BITS-1:0]         i_prio,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [PAYLOAD_BITS-1:0]      o_head_payload,
    output logic [PRIO_BITS-1:0]         o_head_prio,
    output logic                         o_is_empty,
    output logic [CNT_W-1:0]             o_fill_count,
    output logic                         o_overflow
);

    logic                      w_accept;
    logic                      w_full;
    spq_pkg::t_cell_ctrl       w_ctrl;
    logic                      w_ovf;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          r_count;

    logic                      r_out_valid;
    logic [PAYLOAD_BITS-1:0]   r_head_payload;
    logic [PRIO_BITS-1:0]      r_head_prio;
    logic                      r_is_empty;
    logic [CNT_W-1:0]          r_fill_count;
    logic                      r_overflow;

    logic [CAPACITY-1:0]       w_occ;
    logic [CAPACITY-1:0]       w_ge;
    logic [PRIO_BITS-1:0]      w_prio      [CAPACITY];
    logic [PAYLOAD_BITS-1:0]   w_payload   [CAPACITY];
    logic [PRIO_BITS-1:0]      w_next_prio [CAPACITY];
    logic [PAYLOAD_BITS-1:0]   w_next_pl   [CAPACITY];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_ctrl  = '0;
        w_ovf   = 1'b0;
        n_count = r_count;
        unique case (spq_pkg::t_cmd'(i_cmd))
            spq_pkg::CMD_INSERT: begin
                if (w_full) begin
                    w_ovf = 1'b1;
                end else begin
                    w_ctrl.insert = w_accept;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            spq_pkg::CMD_POP: begin
                if (r_count != '0) begin
                    w_ctrl.pop = w_accept;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    w_left_ge;
        logic [PRIO_BITS-1:0]    w_left_prio;
        logic [PAYLOAD_BITS-1:0] w_left_payload;
        logic [PRIO_BITS-1:0]    w_right_prio;
        logic [PAYLOAD_BITS-1:0] w_right_payload;

        assign w_occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_left_ge      = 1'b0;
            assign w_left_prio    = i_prio;
            assign w_left_payload = i_payload;
        end else begin : g_inner_left
            assign w_left_ge      = w_ge[g-1];
            assign w_left_prio    = w_prio[g-1];
            assign w_left_payload = w_payload[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_prio    = w_prio[g];
            assign w_right_payload = w_payload[g];
        end else begin : g_inner_right
            assign w_right_prio    = w_prio[g+1];
            assign w_right_payload = w_payload[g+1];
        end

        spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .PRIO_BITS    (PRIO_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctrl          (w_ctrl),
            .i_occupied      (w_occ[g]),
            .i_new_prio      (i_prio),
            .i_new_payload   (i_payload),
            .i_left_ge       (w_left_ge),
            .i_left_prio     (w_left_prio),
            .i_left_payload  (w_left_payload),
            .i_right_prio    (w_right_prio),
            .i_right_payload (w_right_payload),
            .o_ge            (w_ge[g]),
            .o_prio          (w_prio[g]),
            .o_payload       (w_payload[g]),
            .o_next_prio     (w_next_prio[g]),
            .o_next_payload  (w_next_pl[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head_payload <= (n_count != '0) ? w_next_pl[0]   : '0;
            r_head_prio    <= (n_count != '0) ? w_next_prio[0] : '0;
            r_is_empty     <= (n_count == '0);
            r_fill_count   <= n_count;
            r_overflow     <= w_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_head_payload = r_head_payload;
    assign o_head_prio    = r_head_prio;
    assign o_is_empty     = r_is_empty;
    assign o_fill_count   = r_fill_count;
    assign o_overflow     = r_overflow;

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "count beyond capacity")
    `SPQ_ASSERT(a_empty_flag, i_clk, i_rst_n, r_out_valid |-> (r_is_empty == (r_fill_count == '0)), "empty flag disagrees with count")
    `SPQ_ASSERT(a_pop_count, i_clk, i_rst_n, w_ctrl.pop |=> (r_count == $past(r_count) - CNT_W'(1)), "pop did not drop count")
    `SPQ_ASSERT(a_ovf_full, i_clk, i_rst_n, (w_accept && w_ovf) |=> (r_count == CNT_W'(CAPACITY) && r_overflow), "dropped insert changed queue")
    `SPQ_ASSERT(a_result_follows, i_clk, i_rst_n, w_accept |=> r_out_valid, "accepted item gave no result")

endmodule
